// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and defaults for the sorted priority queue cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] key;
        logic        [31:0] payload;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] head_key;
        logic        [31:0] head_payload;
        logic               is_empty;
        logic               is_full;
        logic        [6:0]  entry_count;
        logic               rejected;
    } t_out_item;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic               do_ins;
        logic               do_rem;
        logic signed [31:0] key;
    } t_cmd;

endpackage

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; compares it with the broadcast key and shifts with its
// neighbours on insert (towards the tail) or remove (towards the head).
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PAYLOAD_WIDTH = spq_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spq_pkg::t_cmd            i_cmd,
    input  logic [PAYLOAD_WIDTH-1:0] i_new_payload,
    input  logic                     i_prev_place,
    input  logic                     i_prev_valid,
    input  logic signed [31:0]       i_prev_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_prev_payload,
    input  logic                     i_next_valid,
    input  logic signed [31:0]       i_next_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_next_payload,
    output logic                     o_place,
    output logic                     o_valid,
    output logic signed [31:0]       o_key,
    output logic [PAYLOAD_WIDTH-1:0] o_payload,
    output logic                     o_n_valid,
    output logic signed [31:0]       o_n_key,
    output logic [PAYLOAD_WIDTH-1:0] o_n_payload
);
    import spq_pkg::*;

    logic                     r_valid;
    logic signed [31:0]       r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic                     n_valid;
    logic signed [31:0]       n_key;
    logic [PAYLOAD_WIDTH-1:0] n_payload;

    // New entry belongs here or further up: slot empty or key strictly larger
    assign o_place = !r_valid || (r_key > i_cmd.key);

    // Shift from the previous cell, drop in the new entry, or shift from the next
    always_comb begin
        n_valid   = r_valid;
        n_key     = r_key;
        n_payload = r_payload;
        if (i_cmd.do_ins) begin
            if (i_prev_place) begin
                n_valid   = i_prev_valid;
                n_key     = i_prev_key;
                n_payload = i_prev_payload;
            end else if (o_place) begin
                n_valid   = 1'b1;
                n_key     = i_cmd.key;
                n_payload = i_new_payload;
            end
        end else if (i_cmd.do_rem) begin
            n_valid   = i_next_valid;
            n_key     = i_next_key;
            n_payload = i_next_payload;
        end
    end

    // Valid flag is control state; entry payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_valid     = r_valid;
    assign o_key       = r_key;
    assign o_payload   = r_payload;
    assign o_n_valid   = n_valid;
    assign o_n_key     = n_key;
    assign o_n_payload = n_payload;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Min-first queue held in ascending key order in a chain of compare-and-shift
// cells. Equal keys leave in arrival order. Each transaction reports the head,
// empty/full flags, the count and whether an insert was refused.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_item (t_out_item)
//
//  One transaction per cycle unless the output stalls: every cell compares and
//  shifts in the same cycle, so the output register shows the result next cycle.
//  Synchronous active-low reset empties the queue; no clearing pass is needed.
//  A stalled result holds the output register and stalls the input side.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_WIDTH = spq_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_item o_out_item
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                     w_accept;
    logic                     w_full;
    logic                     w_reject;
    t_cmd                     w_cmd;
    logic [PAYLOAD_WIDTH-1:0] w_new_payload;

    logic [CAPACITY-1:0]      w_place;
    logic [CAPACITY-1:0]      w_valid;
    logic signed [31:0]       w_key     [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] w_payload [CAPACITY];

    logic                     w_head_valid;
    logic signed [31:0]       w_head_key;
    logic [PAYLOAD_WIDTH-1:0] w_head_payload;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    t_out_item                r_out_item;
    t_out_item                n_out_item;

    // Accept when the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_reject   = w_accept && (i_in_item.action == ACT_INSERT) && w_full;

    // Broadcast the command to the chain
    assign w_cmd.do_ins  = w_accept && (i_in_item.action == ACT_INSERT) && !w_full;
    assign w_cmd.do_rem  = w_accept && (i_in_item.action == ACT_REMOVE) && (r_count != '0);
    assign w_cmd.key     = i_in_item.key;
    assign w_new_payload = PAYLOAD_WIDTH'(i_in_item.payload);

    // Build the cell chain; ends see no neighbour
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     w_pp;
        logic                     w_pv;
        logic signed [31:0]       w_pk;
        logic [PAYLOAD_WIDTH-1:0] w_pd;
        logic                     w_nv;
        logic signed [31:0]       w_nk;
        logic [PAYLOAD_WIDTH-1:0] w_nd;
        logic                     w_sv;
        logic signed [31:0]       w_sk;
        logic [PAYLOAD_WIDTH-1:0] w_sd;

        if (g == 0) begin : g_first
            assign w_pp = 1'b0;
            assign w_pv = 1'b0;
            assign w_pk = '0;
            assign w_pd = '0;
        end else begin : g_mid_prev
            assign w_pp = w_place[g-1];
            assign w_pv = w_valid[g-1];
            assign w_pk = w_key[g-1];
            assign w_pd = w_payload[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_nv = 1'b0;
            assign w_nk = '0;
            assign w_nd = '0;
        end else begin : g_mid_next
            assign w_nv = w_valid[g+1];
            assign w_nk = w_key[g+1];
            assign w_nd = w_payload[g+1];
        end

        spq_cell #(
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (w_cmd),
            .i_new_payload  (w_new_payload),
            .i_prev_place   (w_pp),
            .i_prev_valid   (w_pv),
            .i_prev_key     (w_pk),
            .i_prev_payload (w_pd),
            .i_next_valid   (w_nv),
            .i_next_key     (w_nk),
            .i_next_payload (w_nd),
            .o_place        (w_place[g]),
            .o_valid        (w_valid[g]),
            .o_key          (w_key[g]),
            .o_payload      (w_payload[g]),
            .o_n_valid      (w_sv),
            .o_n_key        (w_sk),
            .o_n_payload    (w_sd)
        );

        if (g == 0) begin : g_head
            assign w_head_valid   = w_sv;
            assign w_head_key     = w_sk;
            assign w_head_payload = w_sd;
        end
    end

    // Track the entry count
    always_comb begin
        n_count = r_count;
        if (w_cmd.do_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.do_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    // Assemble the result from the head cell's next contents
    always_comb begin
        n_out_item.head_key     = w_head_valid ? w_head_key : '0;
        n_out_item.head_payload = w_head_valid ? 32'(w_head_payload) : '0;
        n_out_item.is_empty     = (n_count == '0);
        n_out_item.is_full      = (n_count == CW'(CAPACITY));
        n_out_item.entry_count  = 7'(n_count);
        n_out_item.rejected     = w_reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output register on accept; hold it otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Occupied cells always match the count
    a_count_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell occupancy disagrees with entry count");

    // Head cell is occupied exactly when the queue is not empty
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !w_valid[0])
        else $error("head cell occupancy wrong");

    // A refused insert is reported only with a full queue
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rejected) |-> o_out_item.is_full)
        else $error("insert refused while not full");

    // An accepted insert grows the queue by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.do_ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the queue");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove transactions through the valid/stall channels,
// keeps its own ordered copy of the queue and checks every head, flag and
// count field of each result. Directed corner cases come first, then random
// traffic in fill, drain and mixed phases with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int          CAPACITY      = DEF_CAPACITY;
    localparam int          PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH;
    localparam logic [31:0] TAG_MASK      = (PAYLOAD_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                            32'((64'd1 << PAYLOAD_WIDTH) - 64'd1);
    localparam int          RANDOM_ITEMS  = 1350;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 200000;

    typedef logic signed [31:0] t_key;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // ------------------------------------------------------------------------
    // Ordered shadow of the queue and the results it predicts
    // ------------------------------------------------------------------------
    class spq_scoreboard;
        t_key        queued_keys[$];
        logic [31:0] queued_tags[$];
        t_out_item   pending_results[$];
        int          mismatches;
        int          results_seen;
        int          inserts;
        int          removes;
        int          refusals;
        int          empty_removes;
        int          full_steps;

        // Apply one accepted transaction to the shadow queue
        function void note_item(t_in_item it);
            t_out_item want;
            t_key      new_key;
            int        pos;
            want    = '0;
            new_key = $signed(it.key);
            if (it.action == ACT_INSERT) begin
                inserts++;
                if (queued_keys.size() >= CAPACITY) begin
                    want.rejected = 1'b1;
                    refusals++;
                end else begin
                    // place behind every key that is equal or smaller
                    pos = 0;
                    while (pos < queued_keys.size() && queued_keys[pos] <= new_key)
                        pos++;
                    queued_keys.insert(pos, new_key);
                    queued_tags.insert(pos, it.payload & TAG_MASK);
                end
            end else begin
                removes++;
                if (queued_keys.size() == 0) begin
                    empty_removes++;
                end else begin
                    void'(queued_keys.pop_front());
                    void'(queued_tags.pop_front());
                end
            end
            if (queued_keys.size() > 0) begin
                want.head_key     = queued_keys[0];
                want.head_payload = queued_tags[0];
            end
            want.is_empty    = (queued_keys.size() == 0);
            want.is_full     = (queued_keys.size() >= CAPACITY);
            want.entry_count = 7'(queued_keys.size());
            if (want.is_full)
                full_steps++;
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, want, got);
            end
        endfunction

        // Check one accepted result against the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            compare_field("head_key",     want.head_key,     got.head_key);
            compare_field("head_payload", want.head_payload, got.head_payload);
            compare_field("is_empty",     32'(want.is_empty),    32'(got.is_empty));
            compare_field("is_full",      32'(want.is_full),     32'(got.is_full));
            compare_field("entry_count",  32'(want.entry_count), 32'(got.entry_count));
            compare_field("rejected",     32'(want.rejected),    32'(got.rejected));
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    spq_scoreboard board = new;

    int          cycle_count = 0;
    int          burst_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_left  = 0;

    sorted_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** sorted_priority_queue: FAILED **");
            $finish;
        end
    end

    // Stall the output in stretches of changing character
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
            default:        i_out_stall <= ((stall_left % 8) < 3);
        endcase
    end

    // Observe both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                board.check_result(o_out_item);
            if (i_in_valid && !o_in_stall)
                board.note_item(i_in_item);
        end
    end

    function automatic t_in_item make_item(logic action, t_key key, logic [31:0] payload);
        t_in_item it;
        it.action  = action;
        it.key     = key;
        it.payload = payload;
        return it;
    endfunction

    // Keys bunch into a narrow window so that ties are common
    function automatic t_key rand_key();
        int   pick;
        t_key k;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            k = $urandom_range(0, 8);
            k = k - 32'sd4;
        end else if (pick == 4) begin
            case ($urandom_range(0, 3))
                0:       k = 32'h8000_0000;
                1:       k = 32'h7FFF_FFFF;
                2:       k = 32'h0000_0000;
                default: k = 32'hFFFF_FFFF;
            endcase
        end else begin
            k = $urandom();
        end
        return k;
    endfunction

    function automatic logic [31:0] rand_payload();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Present one transaction and hold it until accepted
    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Send in bursts with random gaps between them
    task automatic send_paced(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_item(it);
    endtask

    initial begin
        t_mix phase;
        int   phase_left;
        logic do_insert;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty remove, key extremes, payload extremes and ties
        send_paced(make_item(ACT_REMOVE, 32'sd0, 32'hFFFF_FFFF));
        send_paced(make_item(ACT_INSERT, 32'sd0, 32'h0000_0000));
        send_paced(make_item(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_paced(make_item(ACT_INSERT, 32'h8000_0000, 32'hA5A5_A5A5));
        send_paced(make_item(ACT_INSERT, -32'sd1, 32'h5A5A_5A5A));
        send_paced(make_item(ACT_INSERT, 32'sd5, 32'h0000_0001));
        send_paced(make_item(ACT_INSERT, 32'sd5, 32'h0000_0002));
        send_paced(make_item(ACT_INSERT, 32'sd5, 32'h0000_0003));
        send_paced(make_item(ACT_INSERT, 32'h7FFF_FFFF, 32'h0000_0000));
        send_paced(make_item(ACT_INSERT, 32'h8000_0000, 32'h8000_0001));
        repeat (10)
            send_paced(make_item(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000));

        // Random: start with a long fill so the full queue and refusals occur early
        phase      = MIX_FILL;
        phase_left = 150;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase      = t_mix'($urandom_range(0, 2));
                phase_left = $urandom_range(40, 160);
            end
            phase_left--;
            case (phase)
                MIX_FILL:  do_insert = ($urandom_range(0, 9) != 0);
                MIX_DRAIN: do_insert = ($urandom_range(0, 9) == 0);
                default:   do_insert = ($urandom_range(0, 1) == 0);
            endcase
            send_paced(make_item(do_insert ? ACT_INSERT : ACT_REMOVE,
                                 rand_key(), rand_payload()));
        end

        // Drain outstanding results
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (board.pending_results.size() != 0) begin
            board.mismatches++;
            $display("%0t: %0d results never arrived", $time, board.pending_results.size());
        end

        $display("Covered %0d inserts (%0d refused on a full queue) and %0d removes (%0d on empty).",
                 board.inserts, board.refusals, board.removes, board.empty_removes);
        $display("Checked %0d results; %0d steps left the queue at capacity; %0d mismatches.",
                 board.results_seen, board.full_steps, board.mismatches);
        if (board.mismatches == 0)
            $display("** sorted_priority_queue: PASSED **");
        else
            $display("** sorted_priority_queue: FAILED **");
        $finish;
    end

endmodule
